// ===== hdl/cdes_pkg.sv =====
// Shared types and constants for the calorimeter digit energy sum core.
// No dependencies; every other file in hdl/ depends on this package.
`default_nettype none

package cdes_pkg;

  // Item field widths
  localparam int KIND_W     = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int PEAK_W     = 12;
  localparam int PTIME_W    = 16;
  localparam int INTEG_W    = 19;
  localparam int SAMPLES_W  = 10;
  localparam int ENERGY_W   = 32;

  // Coarse time is adc_time[14:6]
  localparam int COARSE_LSB = 6;
  localparam int COARSE_W   = 9;
  localparam int COARSE_MSB = COARSE_LSB + COARSE_W - 1;

  // Pedestal per sample and on the peak
  localparam int PEDESTAL   = 100;
  localparam int PED_W      = 17;   // 1023 * 100 fits in 17 bits
  localparam int THR_EXT_W  = PEAK_W + 1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_FWD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BRL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOE = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int THR_W      = 12;
  localparam int MASK_W     = 6;
  localparam int WIN_W      = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FWD_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRL_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 3'd7;

  localparam logic [THR_W-1:0]  RST_FWD_THR  = 12'd64;
  localparam logic [THR_W-1:0]  RST_BRL_THR  = 12'd20;
  localparam logic [MASK_W-1:0] RST_ROW_MIN  = 6'd26;
  localparam logic [MASK_W-1:0] RST_ROW_MAX  = 6'd32;
  localparam logic [MASK_W-1:0] RST_COL_MIN  = 6'd26;
  localparam logic [MASK_W-1:0] RST_COL_MAX  = 6'd32;
  localparam logic [WIN_W-1:0]  RST_WIN_LOW  = 9'd15;
  localparam logic [WIN_W-1:0]  RST_WIN_HIGH = 9'd50;

  typedef struct packed {
    logic [THR_W-1:0]  fwd_thr;
    logic [THR_W-1:0]  brl_thr;
    logic [MASK_W-1:0] row_min;
    logic [MASK_W-1:0] row_max;
    logic [MASK_W-1:0] col_min;
    logic [MASK_W-1:0] col_max;
    logic [WIN_W-1:0]  win_low;
    logic [WIN_W-1:0]  win_high;
  } cdes_cfg_t;

  // Registered input item
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     column;
    logic [PEAK_W-1:0]    adc_peak;
    logic [PTIME_W-1:0]   adc_time;
    logic [INTEG_W-1:0]   adc_integral;
    logic [SAMPLES_W-1:0] sample_count;
  } cdes_item_t;

  // Accumulator operation produced by the classifier
  typedef struct packed {
    logic               fwd_add;
    logic               brl_add;
    logic               eoe;
    logic [INTEG_W-1:0] value;
  } cdes_op_t;

endpackage

`default_nettype wire

// ===== hdl/cdes_if.sv =====
// Valid/ready channel interfaces for the hit input and the energy result.
// Depends on cdes_pkg for field widths.
`default_nettype none

interface cdes_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cdes_pkg::KIND_W-1:0]           kind;
  logic [cdes_pkg::ROW_W-1:0]            row;
  logic [cdes_pkg::COL_W-1:0]            column;
  logic [cdes_pkg::PEAK_W-1:0]           adc_peak;
  logic [cdes_pkg::PTIME_W-1:0]          adc_time;
  logic [cdes_pkg::INTEG_W-1:0]          adc_integral;
  logic [cdes_pkg::SAMPLES_W-1:0]        sample_count;

  modport source (output valid, kind, row, column, adc_peak, adc_time,
                  adc_integral, sample_count, input ready);
  modport sink   (input valid, kind, row, column, adc_peak, adc_time,
                  adc_integral, sample_count, output ready);
endinterface

interface cdes_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdes_pkg::ENERGY_W-1:0] forward_energy;
  logic [cdes_pkg::ENERGY_W-1:0] barrel_energy;

  modport source (output valid, forward_energy, barrel_energy, input ready);
  modport sink   (input valid, forward_energy, barrel_energy, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdes_classify.sv =====
// Hit classification: pedestal, threshold, mask, time window, corrected integral.
// Depends on cdes_pkg.
`default_nettype none

module cdes_classify (
  input  cdes_pkg::cdes_item_t item,
  input  cdes_pkg::cdes_cfg_t  cfg,
  output cdes_pkg::cdes_op_t   op
);
  import cdes_pkg::*;

  logic [COARSE_W-1:0]  coarse;
  logic                 masked;
  logic                 in_window;
  logic [THR_EXT_W-1:0] fwd_limit;
  logic [THR_EXT_W-1:0] brl_limit;
  logic [THR_EXT_W-1:0] peak_ext;
  logic                 fwd_peak_ok;
  logic                 brl_peak_ok;
  logic [PED_W-1:0]     ped;
  logic                 integ_ok;
  logic [INTEG_W-1:0]   corrected;

  always_comb begin
    coarse    = item.adc_time[COARSE_MSB:COARSE_LSB];
    masked    = (item.row >= cfg.row_min) && (item.row <= cfg.row_max) &&
                (item.column >= cfg.col_min) && (item.column <= cfg.col_max);
    in_window = (coarse >= cfg.win_low) && (coarse <= cfg.win_high);

    // peak - 100 > thr  <=>  peak > thr + 100
    peak_ext    = THR_EXT_W'(item.adc_peak);
    fwd_limit   = THR_EXT_W'(cfg.fwd_thr) + THR_EXT_W'(PEDESTAL);
    brl_limit   = THR_EXT_W'(cfg.brl_thr) + THR_EXT_W'(PEDESTAL);
    fwd_peak_ok = peak_ext > fwd_limit;
    brl_peak_ok = peak_ext > brl_limit;

    ped       = PED_W'(item.sample_count) * PED_W'(PEDESTAL);
    integ_ok  = INTEG_W'(ped) <= item.adc_integral;
    corrected = item.adc_integral - INTEG_W'(ped);

    op.fwd_add = (item.kind == KIND_FWD) && !masked && fwd_peak_ok && in_window &&
                 integ_ok;
    op.brl_add = (item.kind == KIND_BRL) && brl_peak_ok && integ_ok;
    op.eoe     = (item.kind == KIND_EOE);
    op.value   = corrected;
  end

endmodule

`default_nettype wire

// ===== hdl/cdes_accum.sv =====
// Saturating forward/barrel accumulators and the result output register.
// Depends on cdes_pkg.
`default_nettype none

module cdes_accum #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  input  cdes_pkg::cdes_op_t            op,
  output logic                          stall,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdes_pkg::ENERGY_W-1:0] forward_energy,
  output logic [cdes_pkg::ENERGY_W-1:0] barrel_energy
);
  import cdes_pkg::*;

  localparam int EXT_W = ((SUM_WIDTH > INTEG_W) ? SUM_WIDTH : INTEG_W) + 1;
  localparam int OUT_W = (SUM_WIDTH > ENERGY_W) ? SUM_WIDTH : ENERGY_W;

  logic [SUM_WIDTH-1:0] fwd_sum_r, fwd_sum_nxt;
  logic [SUM_WIDTH-1:0] brl_sum_r, brl_sum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ENERGY_W-1:0]  fwd_out_r, brl_out_r;

  logic [EXT_W-1:0]     fwd_ext, brl_ext, lim_ext;
  logic [SUM_WIDTH-1:0] fwd_sat, brl_sat;
  logic [OUT_W-1:0]     fwd_wide, brl_wide, out_lim;
  logic [ENERGY_W-1:0]  fwd_clip, brl_clip;
  logic                 go;
  logic                 take_eoe;

  always_comb begin
    stall    = op_valid && op.eoe && out_valid_r && !out_ready;
    go       = op_valid && !stall;
    take_eoe = go && op.eoe;

    lim_ext = EXT_W'({SUM_WIDTH{1'b1}});
    fwd_ext = EXT_W'(fwd_sum_r) + EXT_W'(op.value);
    brl_ext = EXT_W'(brl_sum_r) + EXT_W'(op.value);
    fwd_sat = (fwd_ext > lim_ext) ? {SUM_WIDTH{1'b1}} : fwd_ext[SUM_WIDTH-1:0];
    brl_sat = (brl_ext > lim_ext) ? {SUM_WIDTH{1'b1}} : brl_ext[SUM_WIDTH-1:0];

    // Reported value clips to the 32-bit result field
    out_lim  = OUT_W'({ENERGY_W{1'b1}});
    fwd_wide = OUT_W'(fwd_sum_r);
    brl_wide = OUT_W'(brl_sum_r);
    fwd_clip = (fwd_wide > out_lim) ? {ENERGY_W{1'b1}} : fwd_wide[ENERGY_W-1:0];
    brl_clip = (brl_wide > out_lim) ? {ENERGY_W{1'b1}} : brl_wide[ENERGY_W-1:0];

    fwd_sum_nxt = fwd_sum_r;
    brl_sum_nxt = brl_sum_r;
    if (take_eoe) begin
      fwd_sum_nxt = '0;
      brl_sum_nxt = '0;
    end else if (go) begin
      if (op.fwd_add) fwd_sum_nxt = fwd_sat;
      if (op.brl_add) brl_sum_nxt = brl_sat;
    end

    if (take_eoe) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sum_r   <= '0;
      brl_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_sum_r   <= fwd_sum_nxt;
      brl_sum_r   <= brl_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_eoe) begin
      fwd_out_r <= fwd_clip;
      brl_out_r <= brl_clip;
    end
  end

  assign out_valid      = out_valid_r;
  assign forward_energy = fwd_out_r;
  assign barrel_energy  = brl_out_r;

endmodule

`default_nettype wire

// ===== hdl/calorimeter_digit_energy_sum_core.sv =====
// Calorimeter digit energy sum core: top level.
// An end-of-event result passes through stage A, stage B and the result register.
// Throughput: one transaction per cycle unless stalled; a waiting result holds back
// a later end-of-event in stage B and all behind it, while hits ahead keep flowing.
// Reset (rst_n, synchronous, active low): sums and valid flags cleared, configuration registers to defaults.
// Depends on cdes_pkg, cdes_if, cdes_classify, cdes_accum.
`default_nettype none

module calorimeter_digit_energy_sum_core #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cdes_in_if.sink                         in_ch,
  cdes_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cdes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdes_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cdes_pkg::*;

  // Pipeline:
  //   stage A  input register (item as accepted)
  //   stage B  classified op register (add/clear decision and corrected integral)
  //   accum    saturating sums, then result register on end of event
  // Only an end-of-event in stage B can stall, when the result register is
  // still full and the sink is not taking it.

  cdes_cfg_t  cfg_r;
  cdes_item_t a_item_r;
  logic       a_valid_r, a_valid_nxt;
  cdes_op_t   op_comb;
  cdes_op_t   b_op_r;
  logic       b_valid_r, b_valid_nxt;
  logic       stall_b;
  logic       in_accept;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd_thr  <= RST_FWD_THR;
      cfg_r.brl_thr  <= RST_BRL_THR;
      cfg_r.row_min  <= RST_ROW_MIN;
      cfg_r.row_max  <= RST_ROW_MAX;
      cfg_r.col_min  <= RST_COL_MIN;
      cfg_r.col_max  <= RST_COL_MAX;
      cfg_r.win_low  <= RST_WIN_LOW;
      cfg_r.win_high <= RST_WIN_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FWD_THR:  cfg_r.fwd_thr  <= cfg_wdata[THR_W-1:0];
        CFG_BRL_THR:  cfg_r.brl_thr  <= cfg_wdata[THR_W-1:0];
        CFG_ROW_MIN:  cfg_r.row_min  <= cfg_wdata[MASK_W-1:0];
        CFG_ROW_MAX:  cfg_r.row_max  <= cfg_wdata[MASK_W-1:0];
        CFG_COL_MIN:  cfg_r.col_min  <= cfg_wdata[MASK_W-1:0];
        CFG_COL_MAX:  cfg_r.col_max  <= cfg_wdata[MASK_W-1:0];
        CFG_WIN_LOW:  cfg_r.win_low  <= cfg_wdata[WIN_W-1:0];
        CFG_WIN_HIGH: cfg_r.win_high <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- handshake and stage control ----
  // Stage A takes a new transaction when empty or when it moves on this cycle.
  assign in_ch.ready = !a_valid_r || !stall_b;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (stall_b) begin
      a_valid_nxt = a_valid_r;
    end else begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = stall_b ? b_valid_r : a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_item_r.kind         <= in_ch.kind;
      a_item_r.row          <= in_ch.row;
      a_item_r.column       <= in_ch.column;
      a_item_r.adc_peak     <= in_ch.adc_peak;
      a_item_r.adc_time     <= in_ch.adc_time;
      a_item_r.adc_integral <= in_ch.adc_integral;
      a_item_r.sample_count <= in_ch.sample_count;
    end
  end

  // ---- classification (A -> B) ----
  cdes_classify u_classify (
    .item (a_item_r),
    .cfg  (cfg_r),
    .op   (op_comb)
  );

  // Stage B payload; a dropped hit or unused kind travels as an op with no flags
  always_ff @(posedge clk) begin
    if (!stall_b) begin
      b_op_r <= op_comb;
    end
  end

  // ---- accumulators and result register ----
  cdes_accum #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (b_valid_r),
    .op             (b_op_r),
    .stall          (stall_b),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .forward_energy (out_ch.forward_energy),
    .barrel_energy  (out_ch.barrel_energy)
  );

endmodule

`default_nettype wire
